FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication property, checked on rising clock, off during reset.
`define BHT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define BHT_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/core/bht_pkg.sv
// Shared types and constants for the bucketed hash table.
`default_nettype none

package bht_pkg;

  localparam int unsigned KeyW     = 31;
  localparam int unsigned DataW    = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned EntryW   = KeyW + DataW;

  typedef enum logic {
    FuncInsert = 1'b0,
    FuncLookup = 1'b1
  } func_e;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StMissing = 2'd2
  } status_e;

  typedef struct packed {
    logic            start;
    logic [KeyW-1:0] key;
  } mod_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/bht_if.sv
// Valid/ready channel interfaces for requests and responses.
`default_nettype none

interface bht_in_if;
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic        [bht_pkg::KeyW-1:0]    key;
  logic signed [bht_pkg::DataW-1:0]   data_in;

  modport source (output valid, output func, output key, output data_in, input ready);
  modport sink   (input valid, input func, input key, input data_in, output ready);
endinterface

interface bht_out_if;
  logic                               valid;
  logic                               ready;
  logic        [bht_pkg::StatusW-1:0] status;
  logic signed [bht_pkg::DataW-1:0]   data_out;

  modport source (output valid, output status, output data_out, input ready);
  modport sink   (input valid, input status, input data_out, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bucketed_hash_table.sv
// Bucketed key-value store: insert into first free slot, lookup by linear slot scan.
// Each request passes the key hash, then the fill-count read; an insert, or a lookup in
// an empty bucket, ends there; else the lookup reads used slots in order until a match.
// One transaction at a time: next input accepted the cycle after the result is loaded;
// a result still waiting at the output holds the finished transaction in StDone.
// Reset clears per-bucket fill counts at once; slot RAM contents need no clearing.
`default_nettype none

module bucketed_hash_table #(
  parameter int unsigned NumBuckets     = 5,
  parameter int unsigned SlotsPerBucket = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bht_in_if.sink     in_i,
  bht_out_if.source  out_o
);

  `include "assert_macros.svh"

  localparam int unsigned Total = NumBuckets * SlotsPerBucket;
  localparam int unsigned AW    = (Total > 1) ? $clog2(Total) : 1;
  localparam int unsigned BW    = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
  localparam int unsigned CW    = $clog2(SlotsPerBucket + 1);
  localparam int unsigned SumW  = AW + CW;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StHash  = 5'b00010,
    StCount = 5'b00100,
    StScan  = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic                          func_q;
  logic [bht_pkg::KeyW-1:0]      key_q;
  logic [bht_pkg::DataW-1:0]     data_q;
  logic [BW-1:0]                 bucket_q;
  logic [AW-1:0]                 base_q;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [CW-1:0]                 slot_q, slot_d;
  logic                          pend_q, pend_d;
  logic [NumBuckets-1:0]         cval_q, cval_d;
  logic [bht_pkg::StatusW-1:0]   res_status_q, res_status_d;
  logic [bht_pkg::DataW-1:0]     res_data_q, res_data_d;
  logic                          out_valid_q, out_valid_d;
  logic [bht_pkg::StatusW-1:0]   out_status_q;
  logic [bht_pkg::DataW-1:0]     out_data_q;
  logic                          out_load;

  logic                          accept;
  bht_pkg::mod_req_t             mod_req;
  logic                          mod_done;
  logic [BW-1:0]                 mod_bucket;

  logic [CW-1:0]                 crdata;
  logic [CW-1:0]                 cnt_now;
  logic                          ins_we;
  logic [AW-1:0]                 dwaddr;
  logic [AW-1:0]                 draddr;
  logic [bht_pkg::EntryW-1:0]    drdata;
  logic                          issue;
  logic                          hit;

  assign in_i.ready    = (state_q == StIdle);
  assign accept        = in_i.valid && in_i.ready;
  assign mod_req.start = accept;
  assign mod_req.key   = in_i.key;

  bht_mod #(
    .NumBuckets(NumBuckets)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mod_req),
    .done_o  (mod_done),
    .bucket_o(mod_bucket)
  );

  assign cnt_now = cval_q[bucket_q] ? crdata : '0;
  assign ins_we  = (state_q == StCount) && (func_q == bht_pkg::FuncInsert) &&
                   (cnt_now != CW'(SlotsPerBucket));
  assign dwaddr  = AW'(SumW'(base_q) + SumW'(cnt_now));
  assign draddr  = AW'(SumW'(base_q) + SumW'(slot_q));

  bht_ram #(
    .Width(CW),
    .Depth(NumBuckets)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (ins_we),
    .waddr_i(bucket_q),
    .wdata_i(cnt_now + 1'b1),
    .raddr_i(mod_bucket),
    .rdata_o(crdata)
  );

  bht_ram #(
    .Width(bht_pkg::EntryW),
    .Depth(Total)
  ) u_slot_ram (
    .clk_i  (clk_i),
    .we_i   (ins_we),
    .waddr_i(dwaddr),
    .wdata_i({key_q, data_q}),
    .raddr_i(draddr),
    .rdata_o(drdata)
  );

  assign issue = (slot_q < cnt_q);
  assign hit   = pend_q && (drdata[bht_pkg::EntryW-1:bht_pkg::DataW] == key_q);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    slot_d       = slot_q;
    pend_d       = 1'b0;
    cval_d       = cval_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    out_load     = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StHash;
        end
      end
      StHash: begin
        if (mod_done) begin
          state_d = StCount;
        end
      end
      StCount: begin
        res_data_d = '1;
        cnt_d      = cnt_now;
        slot_d     = '0;
        if (func_q == bht_pkg::FuncInsert) begin
          state_d = StDone;
          if (ins_we) begin
            res_status_d     = bht_pkg::StOk;
            cval_d[bucket_q] = 1'b1;
          end else begin
            res_status_d = bht_pkg::StFull;
          end
        end else if (cnt_now == '0) begin
          res_status_d = bht_pkg::StMissing;
          state_d      = StDone;
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (hit) begin
          res_status_d = bht_pkg::StOk;
          res_data_d   = drdata[bht_pkg::DataW-1:0];
          state_d      = StDone;
        end else if (!issue) begin
          res_status_d = bht_pkg::StMissing;
          state_d      = StDone;
        end else begin
          slot_d = slot_q + 1'b1;
          pend_d = 1'b1;
        end
      end
      StDone: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pend_q      <= 1'b0;
      cval_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      cval_q      <= cval_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_i.func;
      key_q  <= in_i.key;
      data_q <= in_i.data_in;
    end
    if (mod_done) begin
      bucket_q <= mod_bucket;
      base_q   <= AW'(32'(mod_bucket) * SlotsPerBucket);
    end
    cnt_q        <= cnt_d;
    slot_q       <= slot_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_data_q   <= res_data_q;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.status   = out_status_q;
  assign out_o.data_out = out_data_q;

  `BHT_ASSERT(a_accept_blocks, clk_i, rst_ni, accept |=> !in_i.ready,
    "input accepted while a transaction is in flight")
  `BHT_ASSERT(a_pend_in_scan, clk_i, rst_ni,
    pend_q |-> (state_q == StScan && slot_q != '0 && slot_q <= cnt_q),
    "slot read outstanding outside the bucket scan")
  `BHT_ASSERT(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == StDone),
    "response raised without a finished transaction")
  `BHT_ASSERT_NEVER(a_mod_done_hash, clk_i, rst_ni, mod_done && state_q != StHash,
    "bucket index ready outside the hash phase")

endmodule

`default_nettype wire

FILE: rtl/core/bht_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module bht_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 4,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/bht_mod.sv
// Key modulo bucket count by reciprocal multiplication, three pipelined steps.
`default_nettype none

module bht_mod #(
  parameter  int unsigned NumBuckets = 5,
  localparam int unsigned BW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bht_pkg::mod_req_t req_i,
  output logic                   done_o,
  output logic [BW-1:0]          bucket_o
);

  // floor(key / NumBuckets) == (key * Recip) >> Shift for every key of KeyW bits
  localparam int unsigned Shift     = bht_pkg::KeyW + $clog2(NumBuckets);
  localparam logic [63:0] RecipFull =
    ((64'd1 << Shift) + 64'(NumBuckets) - 64'd1) / 64'(NumBuckets);
  localparam logic [31:0] Recip     = RecipFull[31:0];

  logic                     mul_q;
  logic                     sub_q;
  logic                     done_q;
  logic [bht_pkg::KeyW-1:0] key_q;
  logic [bht_pkg::KeyW-1:0] quot_q;
  logic [BW-1:0]            rem_q;
  logic [63:0]              prod;
  logic [bht_pkg::KeyW-1:0] back;

  assign prod = 64'(key_q) * 64'(Recip);
  assign back = bht_pkg::KeyW'(quot_q * bht_pkg::KeyW'(NumBuckets));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_q  <= 1'b0;
      sub_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      mul_q  <= req_i.start;
      sub_q  <= mul_q;
      done_q <= sub_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      key_q <= req_i.key;
    end
    if (mul_q) begin
      quot_q <= bht_pkg::KeyW'(prod >> Shift);
    end
    if (sub_q) begin
      rem_q <= BW'(key_q - back);
    end
  end

  assign done_o   = done_q;
  assign bucket_o = rem_q;

endmodule

`default_nettype wire
